[rtl/atal_pkg.sv]
// Package for the accelerometer tilt-angle block: datapath widths, states,
// the CORDIC arctangent table and the inverse-gain constant.
// Depends on nothing.
`default_nettype none
package atal_pkg;
	localparam int CW = 28;          // cordic x/y width
	localparam int ZW = 26;          // cordic angle width, degrees Q16
	localparam int GW = 16;          // inverse gain constant width
	localparam int AW = CW + GW;     // gain accumulator width
	localparam logic [GW-1:0] INV_GAIN = 16'd39797;
	localparam logic [ZW-1:0] DEG90 = 26'(90 * 65536);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROLL,
		ST_GAIN,
		ST_PITCH,
		ST_FMUL,
		ST_FUPD
	} state_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic [21:0] atan_q16(input logic [4:0] i);
		case (i)
			5'd0: atan_q16 = 22'd2949120;
			5'd1: atan_q16 = 22'd1740967;
			5'd2: atan_q16 = 22'd919879;
			5'd3: atan_q16 = 22'd466945;
			5'd4: atan_q16 = 22'd234379;
			5'd5: atan_q16 = 22'd117304;
			5'd6: atan_q16 = 22'd58666;
			5'd7: atan_q16 = 22'd29335;
			5'd8: atan_q16 = 22'd14668;
			5'd9: atan_q16 = 22'd7334;
			5'd10: atan_q16 = 22'd3667;
			5'd11: atan_q16 = 22'd1833;
			5'd12: atan_q16 = 22'd917;
			5'd13: atan_q16 = 22'd458;
			5'd14: atan_q16 = 22'd229;
			5'd15: atan_q16 = 22'd115;
			5'd16: atan_q16 = 22'd57;
			5'd17: atan_q16 = 22'd29;
			5'd18: atan_q16 = 22'd14;
			5'd19: atan_q16 = 22'd7;
			5'd20: atan_q16 = 22'd4;
			5'd21: atan_q16 = 22'd2;
			5'd22: atan_q16 = 22'd1;
			default: atan_q16 = 22'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

[rtl/atal_cordic.sv]
// Iterative vectoring CORDIC, one micro-rotation per cycle, angle in degrees Q16.
// Depends on atal_pkg for widths and the arctangent table.
`default_nettype none
module atal_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic signed [atal_pkg::CW-1:0] x_in,
	input  wire logic signed [atal_pkg::CW-1:0] y_in,
	output logic                             done,
	output logic signed [atal_pkg::ZW-1:0]   z_out,
	output logic signed [atal_pkg::CW-1:0]   mag_out
);
	import atal_pkg::*;

	localparam logic [4:0] LAST = 5'(STEPS - 1);

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, at;
	logic [4:0] i_q;
	logic busy_q, done_q, zero_q;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({4'd0, atan_q16(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			if (x_in[CW-1] && !y_in[CW-1]) begin
				x_q <= y_in;
				y_q <= -x_in;
				z_q <= DEG90;
			end else if (x_in[CW-1]) begin
				x_q <= -y_in;
				y_q <= x_in;
				z_q <= -DEG90;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done = done_q;
	assign z_out = zero_q ? '0 : z_q;
	assign mag_out = x_q;
endmodule
`default_nettype wire

[rtl/accel_tilt_angle_lowpass.sv]
// Top level of the accelerometer tilt-angle block with low-pass smoothing.
// Depends on atal_pkg and atal_cordic.
//
// Takes one three-axis sample per input transfer and returns one result transfer with raw
// and filtered roll and pitch in signed degrees with ANGLE_FRAC_BITS fraction bits (Q8 at
// the default), plus whole degrees and tenths digit. Each sample goes through a roll pass
// of the shared CORDIC unit, the bit-serial inverse-gain multiply, a pitch pass of the
// same unit and the filter multiply and update. A new sample is accepted only in idle,
// once the previous one has left the filter update. A new sample is taken while the
// previous result still waits on the output; the next filter update then waits for it.
// smoothing_weight sits at byte address 0 of the APB port, reset 128; values above 256
// act as 256. Angle outputs are 8+ANGLE_FRAC_BITS and 9+ANGLE_FRAC_BITS wide.
`default_nettype none
module accel_tilt_angle_lowpass #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [15:0]                  accel_x,
	input  wire logic signed [15:0]                  accel_y,
	input  wire logic signed [15:0]                  accel_z,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [7+ANGLE_FRAC_BITS:0]        pitch_now,
	output logic signed [8+ANGLE_FRAC_BITS:0]        roll_now,
	output logic signed [7+ANGLE_FRAC_BITS:0]        pitch_smooth,
	output logic signed [8+ANGLE_FRAC_BITS:0]        roll_smooth,
	output logic signed [7:0]                        pitch_whole,
	output logic [3:0]                               pitch_tenths,
	output logic signed [8:0]                        roll_whole,
	output logic [3:0]                               roll_tenths
);
	import atal_pkg::*;

	localparam int F = ANGLE_FRAC_BITS;
	localparam int RS = 16 - F;
	localparam int PW = 8 + F;
	localparam int RW = 9 + F;
	localparam logic signed [ZW-1:0] HALF = ZW'(1 << (RS - 1));
	localparam logic signed [ZW-1:0] LIM_P = ZW'(90 << F);
	localparam logic signed [ZW-1:0] LIM_R = ZW'(180 << F);

	state_t state_q, state_d;

	logic [8:0] weight_q;
	logic [9:0] w_eff;
	logic cfg_wr;

	logic signed [CW-1:0] negax_q, cx_in, cy_in, c_mag;
	logic signed [ZW-1:0] c_z, zr, zc_r, zc_p;
	logic c_start, c_done;

	logic [AW-1:0] mcand_q, acc_q;
	logic [4:0] k_q;

	logic signed [PW-1:0] pitch_q, pf_q, pf_new;
	logic signed [RW-1:0] roll_q, rf_q, rf_new;
	logic signed [PW+10:0] pprod_s1;
	logic signed [RW+10:0] rprod_s1;
	logic [PW-1:0] pm;
	logic [RW-1:0] rm;
	logic [F+3:0] pt10, rt10;
	logic out_valid_q, load_out;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {23'd0, weight_q};
	assign w_eff = (weight_q > 9'd256) ? 10'd256 : {1'b0, weight_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= 9'd128;
		end else if (cfg_wr) begin
			weight_q <= pwdata[8:0];
		end
	end

	// angle engine
	assign in_ready = (state_q == ST_IDLE);
	assign c_start = (in_valid && in_ready) || (state_q == ST_GAIN && k_q == 5'd16);
	assign cx_in = (state_q == ST_IDLE) ? CW'(accel_z) <<< 8 : CW'(acc_q[AW-1:GW]);
	assign cy_in = (state_q == ST_IDLE) ? CW'(accel_y) <<< 8 : negax_q;

	atal_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .x_in(cx_in), .y_in(cy_in),
		.done(c_done), .z_out(c_z), .mag_out(c_mag)
	);

	// rounding to the output fraction, then saturation
	assign zr = (c_z + HALF) >>> RS;
	assign zc_r = (zr > LIM_R) ? LIM_R : ((zr < -LIM_R) ? -LIM_R : zr);
	assign zc_p = (zr > LIM_P) ? LIM_P : ((zr < -LIM_P) ? -LIM_P : zr);

	assign load_out = (state_q == ST_FUPD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			pf_q <= '0;
			rf_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
				pf_q <= pf_new;
				rf_q <= rf_new;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_ROLL;
			ST_ROLL:  if (c_done) state_d = ST_GAIN;
			ST_GAIN:  if (k_q == 5'd16) state_d = ST_PITCH;
			ST_PITCH: if (c_done) state_d = ST_FMUL;
			ST_FMUL:  state_d = ST_FUPD;
			ST_FUPD:  if (load_out) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// datapath: bit-serial inverse-gain multiply, filter products
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			negax_q <= -(CW'(accel_x) <<< 8);
		end
		if (state_q == ST_ROLL && c_done) begin
			roll_q <= RW'(zc_r);
			mcand_q <= AW'(c_mag);
			acc_q <= AW'(32768);
			k_q <= '0;
		end else if (state_q == ST_GAIN && k_q != 5'd16) begin
			if (INV_GAIN[k_q[3:0]]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q << 1;
			k_q <= k_q + 5'd1;
		end
		if (state_q == ST_PITCH && c_done) begin
			pitch_q <= PW'(zc_p);
		end
		if (state_q == ST_FMUL) begin
			pprod_s1 <= $signed({1'b0, w_eff}) * ((PW+1)'(pitch_q) - (PW+1)'(pf_q));
			rprod_s1 <= $signed({1'b0, w_eff}) * ((RW+1)'(roll_q) - (RW+1)'(rf_q));
		end
	end

	assign pf_new = pf_q + PW'(pprod_s1 >>> 8);
	assign rf_new = rf_q + RW'(rprod_s1 >>> 8);
	assign pm = pf_new[PW-1] ? PW'(-pf_new) : PW'(pf_new);
	assign rm = rf_new[RW-1] ? RW'(-rf_new) : RW'(rf_new);
	assign pt10 = (F+4)'(pm[F-1:0]) * (F+4)'(10);
	assign rt10 = (F+4)'(rm[F-1:0]) * (F+4)'(10);

	always_ff @(posedge clk) begin
		if (load_out) begin
			pitch_now <= pitch_q;
			roll_now <= roll_q;
			pitch_smooth <= pf_new;
			roll_smooth <= rf_new;
			pitch_whole <= pf_new[PW-1] ? -8'(pm[PW-1:F]) : 8'(pm[PW-1:F]);
			roll_whole <= rf_new[RW-1] ? -9'(rm[RW-1:F]) : 9'(rm[RW-1:F]);
			pitch_tenths <= pt10[F+3:F];
			roll_tenths <= rt10[F+3:F];
		end
	end

	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_ROLL))
		else $error("accepted sample did not start the roll pass");
	a_done_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		c_done |-> (state_q == ST_ROLL || state_q == ST_PITCH))
		else $error("cordic finished outside a pass");
	a_store_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(pf_q) && $stable(rf_q))
		else $error("filter store changed while a result waits");
endmodule
`default_nettype wire
